/* rtl/core/ecint_pkg.sv */
// ----------------------------------------------------------------------------
// ecint_pkg: shared types and constants of the easing curve interpolator
// Default widths, configuration register codes and curve mode codes.
// ----------------------------------------------------------------------------
package ecint_pkg;

  localparam int unsigned TIME_BITS_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned MODE_BITS      = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CURVE_MODE    = 2'd0,
    CFG_START_VALUE   = 2'd1,
    CFG_CHANGE_AMOUNT = 2'd2,
    CFG_DURATION      = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LINEAR       = 3'd0,
    MODE_QUAD_IN      = 3'd1,
    MODE_QUAD_OUT     = 3'd2,
    MODE_QUART_IN     = 3'd3,
    MODE_QUART_OUT    = 3'd4,
    MODE_QUART_IN_OUT = 3'd5
  } curve_mode_e;

endpackage

/* rtl/core/ecint_div_cell.sv */
// ----------------------------------------------------------------------------
// ecint_div_cell: one cell of the restoring divider chain
// Double the partial remainder, subtract the divisor when it fits and shift
// the resulting quotient bit in. One cell per fraction bit.
// ----------------------------------------------------------------------------
module ecint_div_cell #(
  parameter int unsigned TimeBits = ecint_pkg::TIME_BITS_DEF,
  parameter int unsigned FracBits = ecint_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  logic [TimeBits-1:0] up_rem_i,
  input  logic [FracBits-1:0] up_quo_i,
  input  logic                up_done_i,
  input  logic [TimeBits-1:0] divisor_i,
  output logic                dn_valid_o,
  input  logic                dn_ready_i,
  output logic [TimeBits-1:0] dn_rem_o,
  output logic [FracBits-1:0] dn_quo_o,
  output logic                dn_done_o
);

  logic                valid_q;
  logic                adv;
  logic [TimeBits:0]   dbl;
  logic [TimeBits:0]   diff;
  logic                fits;
  logic [TimeBits-1:0] rem_d, rem_q;
  logic [FracBits-1:0] quo_d, quo_q;
  logic                done_q;

  assign adv = !valid_q || dn_ready_i;
  assign up_ready_o = adv;

  always_comb begin
    dbl   = {up_rem_i, 1'b0};
    diff  = dbl - {1'b0, divisor_i};
    fits  = dbl >= {1'b0, divisor_i};
    rem_d = fits ? diff[TimeBits-1:0] : dbl[TimeBits-1:0];
    quo_d = {up_quo_i[FracBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_valid_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      done_q <= up_done_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_rem_o   = rem_q;
  assign dn_quo_o   = quo_q;
  assign dn_done_o  = done_q;

  // partial remainder stays below the divisor on every live division
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !done_q |-> rem_q < divisor_i)
    else $error("divider remainder reached the divisor");

endmodule

/* rtl/core/ecint_curve.sv */
// ----------------------------------------------------------------------------
// ecint_curve: easing polynomial in Q1.FracBits
// Pick the operand, square it twice with rounding, then select the curve.
// Four registered stages.
// ----------------------------------------------------------------------------
module ecint_curve #(
  parameter int unsigned FracBits = ecint_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ecint_pkg::MODE_BITS-1:0] mode_i,
  input  logic                           up_valid_i,
  output logic                           up_ready_o,
  input  logic [FracBits-1:0]            up_quo_i,
  input  logic                           up_done_i,
  output logic                           dn_valid_o,
  input  logic                           dn_ready_i,
  output logic [FracBits:0]              dn_f_o,
  output logic                           dn_done_o
);

  localparam int unsigned SqW = 2 * FracBits + 2;
  localparam logic [FracBits:0] One = (FracBits + 1)'(1) << FracBits;
  localparam logic [SqW-1:0] HalfSq = SqW'(1) << (FracBits - 1);

  logic [3:0] v_q;
  logic [3:0] adv;

  logic [FracBits:0] u_in, v_in, w_in, z_in, a_d;
  logic              half_in;
  logic [SqW-1:0]    sq1, sq2;
  logic [FracBits+1:0] p_inc;
  logic [FracBits:0] p_half, f_d;

  logic [FracBits:0] u1_q, a1_q;
  logic              half1_q, done1_q;
  logic [FracBits:0] u2_q, s2_q;
  logic              half2_q, done2_q;
  logic [FracBits:0] u3_q, s3_q, p3_q;
  logic              half3_q, done3_q;
  logic [FracBits:0] f4_q;
  logic              done4_q;

  always_comb begin
    adv[3] = !v_q[3] || dn_ready_i;
    adv[2] = !v_q[2] || adv[3];
    adv[1] = !v_q[1] || adv[2];
    adv[0] = !v_q[0] || adv[1];
  end
  assign up_ready_o = adv[0];

  // operand select: in-out curve splits at half and doubles its argument
  always_comb begin
    u_in    = up_done_i ? One : {1'b0, up_quo_i};
    v_in    = One - u_in;
    half_in = (u_in[FracBits:FracBits-1] == 2'b00);
    w_in    = {u_in[FracBits-1:0], 1'b0};
    z_in    = {v_in[FracBits-1:0], 1'b0};
    case (ecint_pkg::curve_mode_e'(mode_i))
      ecint_pkg::MODE_QUAD_IN,
      ecint_pkg::MODE_QUART_IN:     a_d = u_in;
      ecint_pkg::MODE_QUAD_OUT,
      ecint_pkg::MODE_QUART_OUT:    a_d = v_in;
      ecint_pkg::MODE_QUART_IN_OUT: a_d = half_in ? w_in : z_in;
      default:                      a_d = u_in;
    endcase
  end

  assign sq1 = SqW'(a1_q) * SqW'(a1_q) + HalfSq;
  assign sq2 = SqW'(s2_q) * SqW'(s2_q) + HalfSq;

  always_comb begin
    p_inc  = {1'b0, p3_q} + (FracBits + 2)'(1);
    p_half = p_inc[FracBits+1:1];
    case (ecint_pkg::curve_mode_e'(mode_i))
      ecint_pkg::MODE_QUAD_IN:      f_d = s3_q;
      ecint_pkg::MODE_QUAD_OUT:     f_d = One - s3_q;
      ecint_pkg::MODE_QUART_IN:     f_d = p3_q;
      ecint_pkg::MODE_QUART_OUT:    f_d = One - p3_q;
      ecint_pkg::MODE_QUART_IN_OUT: f_d = half3_q ? p_half : One - p_half;
      default:                      f_d = u3_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= up_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && up_valid_i) begin
      u1_q    <= u_in;
      a1_q    <= a_d;
      half1_q <= half_in;
      done1_q <= up_done_i;
    end
    if (adv[1] && v_q[0]) begin
      u2_q    <= u1_q;
      s2_q    <= sq1[2*FracBits:FracBits];
      half2_q <= half1_q;
      done2_q <= done1_q;
    end
    if (adv[2] && v_q[1]) begin
      u3_q    <= u2_q;
      s3_q    <= s2_q;
      p3_q    <= sq2[2*FracBits:FracBits];
      half3_q <= half2_q;
      done3_q <= done2_q;
    end
    if (adv[3] && v_q[2]) begin
      f4_q    <= f_d;
      done4_q <= done3_q;
    end
  end

  assign dn_valid_o = v_q[3];
  assign dn_f_o     = f4_q;
  assign dn_done_o  = done4_q;

  a_curve_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> f4_q <= One)
    else $error("curve value above one");

endmodule

/* rtl/core/ecint_scale.sv */
// ----------------------------------------------------------------------------
// ecint_scale: scale the curve by the change and add the start value
// Signed multiply with round-half-up, then the output register.
// ----------------------------------------------------------------------------
module ecint_scale #(
  parameter int unsigned ValueBits = ecint_pkg::VALUE_BITS_DEF,
  parameter int unsigned FracBits  = ecint_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [ValueBits-1:0] start_i,
  input  logic signed [ValueBits-1:0] change_i,
  input  logic                        up_valid_i,
  output logic                        up_ready_o,
  input  logic [FracBits:0]           up_f_i,
  input  logic                        up_done_i,
  output logic                        dn_valid_o,
  input  logic                        dn_ready_i,
  output logic signed [ValueBits:0]   dn_eased_o,
  output logic                        dn_done_o
);

  localparam int unsigned PW = ValueBits + FracBits + 2;
  localparam logic signed [PW-1:0] HalfP = PW'(1) << (FracBits - 1);

  logic [1:0] v_q;
  logic [1:0] adv;

  logic signed [PW-1:0]        c_ext, f_ext, prod_d, prod_q;
  logic signed [ValueBits+1:0] shifted, sum;
  logic                        done_a_q;
  logic signed [ValueBits:0]   eased_q;
  logic                        done_q;

  always_comb begin
    adv[1] = !v_q[1] || dn_ready_i;
    adv[0] = !v_q[0] || adv[1];
  end
  assign up_ready_o = adv[0];

  always_comb begin
    c_ext   = PW'(change_i);
    f_ext   = PW'($signed({1'b0, up_f_i}));
    prod_d  = c_ext * f_ext + HalfP;
    // arithmetic shift floors, which gives ties toward plus infinity
    shifted = prod_q[PW-1:FracBits];
    sum     = shifted + (ValueBits + 2)'(start_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= up_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && up_valid_i) begin
      prod_q   <= prod_d;
      done_a_q <= up_done_i;
    end
    if (adv[1] && v_q[0]) begin
      eased_q <= sum[ValueBits:0];
      done_q  <= done_a_q;
    end
  end

  assign dn_valid_o = v_q[1];
  assign dn_eased_o = eased_q;
  assign dn_done_o  = done_q;

endmodule

/* rtl/core/easing_curve_interpolator_top.sv */
// ----------------------------------------------------------------------------
// easing_curve_interpolator_top: Penner easing curves in fixed point
// Returns start + change * f(elapsed / duration) for one elapsed tick count
// per beat, with a done flag once elapsed reaches the duration.
// ----------------------------------------------------------------------------
//
//  channel  direction  beat contents
//  -------  ---------  ---------------------------------------------------
//  s_axis   in         tdata: elapsed
//  m_axis   out        tdata: eased_value; tuser: done_res
//  cfg      in         cfg_index_i selects the register, cfg_data_i value
//
//  One beat per cycle in and out while the output is not stalled; the chain
//  is one input register, FRAC_BITS divider cells (one quotient bit each),
//  four curve stages and two scale stages ending in the output register.
//  Every stage holds its own valid bit and advances when its successor can
//  take a beat, so bubbles collapse and a stalled result still lets new
//  beats enter until the chain fills.
//  Reset clears all valid bits and loads mode linear, start 0, change 0,
//  duration 1. Write configuration only while the chain is empty.
//
module easing_curve_interpolator_top #(
  parameter int unsigned TIME_BITS  = ecint_pkg::TIME_BITS_DEF,
  parameter int unsigned VALUE_BITS = ecint_pkg::VALUE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = ecint_pkg::FRAC_BITS_DEF,
  localparam int unsigned InW  = ((TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input beats
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [InW-1:0]                      s_axis_tdata,  // [TIME_BITS-1:0] elapsed
  // result beats
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [OutW-1:0]                     m_axis_tdata,  // [VALUE_BITS:0] eased_value
  output logic [0:0]                          m_axis_tuser,  // [0] done_res
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ecint_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [ecint_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  // Configuration registers
  logic [ecint_pkg::MODE_BITS-1:0] mode_q;
  logic signed [VALUE_BITS-1:0]    start_q;
  logic signed [VALUE_BITS-1:0]    change_q;
  logic [TIME_BITS-1:0]            dur_q;

  // Always accept configuration; the chain reads the registers directly
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ecint_pkg::MODE_LINEAR;
      start_q  <= '0;
      change_q <= '0;
      dur_q    <= TIME_BITS'(1);
    end else if (cfg_valid_i) begin
      unique case (ecint_pkg::cfg_reg_e'(cfg_index_i))
        ecint_pkg::CFG_CURVE_MODE:    mode_q   <= cfg_data_i[ecint_pkg::MODE_BITS-1:0];
        ecint_pkg::CFG_START_VALUE:   start_q  <= cfg_data_i[VALUE_BITS-1:0];
        ecint_pkg::CFG_CHANGE_AMOUNT: change_q <= cfg_data_i[VALUE_BITS-1:0];
        ecint_pkg::CFG_DURATION:      dur_q    <= cfg_data_i[TIME_BITS-1:0];
      endcase
    end
  end

  // Input register: decide done and seed the remainder.
  // A finished curve (elapsed at or past duration, or zero duration) forces
  // u to one downstream, so the seed only matters for elapsed < duration.
  logic [TIME_BITS-1:0] elapsed;
  logic                 done_in;
  logic                 in_v_q;
  logic                 in_adv;
  logic [TIME_BITS-1:0] rem0_q;
  logic                 done0_q;

  assign elapsed = s_axis_tdata[TIME_BITS-1:0];
  assign done_in = (dur_q == '0) || (elapsed >= dur_q);

  // Divider chain wiring: index 0 is the input register
  logic                 div_valid [FRAC_BITS+1];
  logic                 div_ready [FRAC_BITS+1];
  logic [TIME_BITS-1:0] div_rem   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] div_quo   [FRAC_BITS+1];
  logic                 div_done  [FRAC_BITS+1];

  assign in_adv        = !in_v_q || div_ready[0];
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_adv) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      rem0_q  <= elapsed;
      done0_q <= done_in;
    end
  end

  assign div_valid[0] = in_v_q;
  assign div_rem[0]   = rem0_q;
  assign div_quo[0]   = '0;
  assign div_done[0]  = done0_q;

  // Restoring division, one quotient bit per cell, most significant first
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    ecint_div_cell #(
      .TimeBits (TIME_BITS),
      .FracBits (FRAC_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (div_valid[i]),
      .up_ready_o (div_ready[i]),
      .up_rem_i   (div_rem[i]),
      .up_quo_i   (div_quo[i]),
      .up_done_i  (div_done[i]),
      .divisor_i  (dur_q),
      .dn_valid_o (div_valid[i+1]),
      .dn_ready_i (div_ready[i+1]),
      .dn_rem_o   (div_rem[i+1]),
      .dn_quo_o   (div_quo[i+1]),
      .dn_done_o  (div_done[i+1])
    );
  end

  // Curve evaluation
  logic                 crv_valid, crv_ready;
  logic [FRAC_BITS:0]   crv_f;
  logic                 crv_done;

  ecint_curve #(
    .FracBits (FRAC_BITS)
  ) u_curve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .up_valid_i (div_valid[FRAC_BITS]),
    .up_ready_o (div_ready[FRAC_BITS]),
    .up_quo_i   (div_quo[FRAC_BITS]),
    .up_done_i  (div_done[FRAC_BITS]),
    .dn_valid_o (crv_valid),
    .dn_ready_i (crv_ready),
    .dn_f_o     (crv_f),
    .dn_done_o  (crv_done)
  );

  // Scale and offset; the last stage is the output register
  logic signed [VALUE_BITS:0] eased;
  logic                       done_out;

  ecint_scale #(
    .ValueBits (VALUE_BITS),
    .FracBits  (FRAC_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .change_i   (change_q),
    .up_valid_i (crv_valid),
    .up_ready_o (crv_ready),
    .up_f_i     (crv_f),
    .up_done_i  (crv_done),
    .dn_valid_o (m_axis_tvalid),
    .dn_ready_i (m_axis_tready),
    .dn_eased_o (eased),
    .dn_done_o  (done_out)
  );

  assign m_axis_tdata    = OutW'($unsigned(eased));
  assign m_axis_tuser[0] = done_out;

  // Input backpressure only comes from a full chain behind a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // A finished curve sits at f = 1 in every mode, so it lands on start+change
  a_done_lands_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      eased == ((VALUE_BITS + 1)'(start_q) + (VALUE_BITS + 1)'(change_q)))
    else $error("finished curve did not reach start plus change");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the easing curve interpolator
// Drives elapsed tick counts under several curve settings and computes each
// eased value and done flag independently. Compares every result beat in
// order against that prediction, with random idle gaps on both streams and
// one long receiver hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import ecint_pkg::*;

  localparam int unsigned TB = TIME_BITS_DEF;
  localparam int unsigned VB = VALUE_BITS_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned InW  = ((TB + 7) / 8) * 8;
  localparam int unsigned OutW = ((VB + 1 + 7) / 8) * 8;

  // input register, one divider cell per quotient bit, curve and scale stages
  localparam int unsigned PIPE_LATENCY = FB + 7;
  localparam int unsigned DRAIN_MARGIN = 8;

  localparam longint unsigned Q_ONE  = 64'd1 << FB;
  localparam longint unsigned Q_HALF = 64'd1 << (FB - 1);

  // mode codes that have no name in the package; they run as linear
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned MODE_CODES = 1 << MODE_BITS;

  localparam logic signed [VB-1:0] VALUE_MIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [VB-1:0] VALUE_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic [TB-1:0]        TIME_MAX  = '1;

  localparam int unsigned RANDOM_ITEMS   = 700;
  localparam int unsigned BACKLOG_ITEMS  = 120;
  localparam int unsigned HOLD_OFF_TICKS = 300;

  typedef struct packed {
    logic signed [VB:0] value;
    logic               done;
  } ease_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;   // [TB-1:0] elapsed
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;   // [VB:0] eased_value
  logic [0:0]      m_axis_tuser;   // [0] done_res
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  // shadow copy of the configuration registers as last written
  logic [MODE_BITS-1:0] shadow_mode;
  logic signed [VB-1:0] shadow_start;
  logic signed [VB-1:0] shadow_change;
  logic [TB-1:0]        shadow_duration;

  ease_result_t pending_eases[$];
  int unsigned  mismatch_count = 0;

  // idle controls, switched per phase by the tests
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned hold_off_request = 0;

  always #10 clk_i = ~clk_i;

  easing_curve_interpolator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Curve arithmetic in Q1.FB
  // --------------------------------------------------------------------------

  // product of two Q values, rounded to nearest with ties up
  function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
    return (a * b + Q_HALF) >> FB;
  endfunction

  function automatic longint unsigned q_pow4(longint unsigned a);
    longint unsigned sq;
    sq = q_mul(a, a);
    return q_mul(sq, sq);
  endfunction

  function automatic longint unsigned curve_shape(logic [MODE_BITS-1:0] mode,
                                                  longint unsigned u);
    longint unsigned v;
    v = Q_ONE - u;
    case (mode)
      MODE_QUAD_IN:   return q_mul(u, u);
      MODE_QUAD_OUT:  return Q_ONE - q_mul(v, v);
      MODE_QUART_IN:  return q_pow4(u);
      MODE_QUART_OUT: return Q_ONE - q_pow4(v);
      MODE_QUART_IN_OUT: begin
        // first half rises as quartic in, second half mirrors quartic out
        if (2 * u < Q_ONE) return (q_pow4(2 * u) + 1) >> 1;
        return Q_ONE - ((q_pow4(2 * v) + 1) >> 1);
      end
      default:        return u;
    endcase
  endfunction

  // eased value and done flag for one elapsed count under the shadow settings
  function automatic ease_result_t predict_eased(logic [TB-1:0] elapsed);
    longint unsigned e, d, u, f;
    longint scaled;
    ease_result_t res;
    e = elapsed;
    d = shadow_duration;
    if (d == 0) begin
      // zero duration parks the curve at its end
      u = Q_ONE;
      res.done = 1'b1;
    end else begin
      res.done = (e >= d);
      if (e > d) e = d;
      u = (e << FB) / d;
    end
    f = curve_shape(shadow_mode, u);
    // arithmetic shift floors, so ties round toward plus infinity
    scaled = (longint'(shadow_change) * longint'(f) + longint'(Q_HALF)) >>> FB;
    res.value = (VB + 1)'(shadow_start + scaled);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stream and configuration drivers
  // --------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Enter and leave at a falling edge. tvalid stays high on return so that
  // back-to-back beats need no second assignment in the same step.
  task automatic send_elapsed(logic [TB-1:0] elapsed);
    int unsigned gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InW'($urandom());   // noise while idle
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InW'(elapsed);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_eases.push_back(predict_eased(elapsed));
    @(negedge clk_i);
  endtask

  // drop tvalid, then wait until every result is back and the chain is empty
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_eases.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + DRAIN_MARGIN) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e index, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_CURVE_MODE:    shadow_mode     = value[MODE_BITS-1:0];
      CFG_START_VALUE:   shadow_start    = value[VB-1:0];
      CFG_CHANGE_AMOUNT: shadow_change   = value[VB-1:0];
      CFG_DURATION:      shadow_duration = value[TB-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Load all four registers once the chain is empty. Upper data bits carry
  // noise, since only the low register bits are kept.
  task automatic program_curve(logic [MODE_BITS-1:0] mode, logic signed [VB-1:0] start,
                               logic signed [VB-1:0] change, logic [TB-1:0] dur);
    logic [CFG_DATA_BITS-1:0] word;
    wait_until_idle();
    word = $urandom();
    word[MODE_BITS-1:0] = mode;
    write_register(CFG_CURVE_MODE, word);
    word = $urandom();
    word[VB-1:0] = start;
    write_register(CFG_START_VALUE, word);
    word = $urandom();
    word[VB-1:0] = change;
    write_register(CFG_CHANGE_AMOUNT, word);
    word = $urandom();
    word[TB-1:0] = dur;
    write_register(CFG_DURATION, word);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [VB-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return '0;
      default: return VB'($urandom());
    endcase
  endfunction

  function automatic logic [TB-1:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)  return '0;
    if (roll < 6)  return TB'(1);
    if (roll < 10) return TIME_MAX;
    if (roll < 50) return TB'($urandom_range(2, 64));
    return TB'($urandom_range(2, TIME_MAX));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset settings: linear, start 0, change 0, duration 1
  task automatic test_reset_defaults();
    send_elapsed('0);
    send_elapsed(TIME_MAX);
  endtask

  // every mode code, the spare ones too, against value and time extremes;
  // even durations land exactly on half; the in-out code is odd, so it gets none
  task automatic test_every_mode();
    logic signed [VB-1:0] start, change;
    logic [TB-1:0] dur;
    for (int m = 0; m < MODE_CODES; m++) begin
      case (m % 4)
        0:       begin start = VALUE_MIN; change = VALUE_MAX; end
        1:       begin start = VALUE_MAX; change = VALUE_MIN; end
        2:       begin start = VALUE_MAX; change = VALUE_MAX; end
        default: begin start = VALUE_MIN; change = VALUE_MIN; end
      endcase
      dur = (m % 2) ? TIME_MAX : TB'(10);
      program_curve(MODE_BITS'(m), start, change, dur);
      send_elapsed(dur / 2);
      send_elapsed(dur - 1);
      send_elapsed((m % 2) ? TIME_MAX : '0);
    end
  endtask

  // zero duration: finished at once, whatever elapsed says
  task automatic test_zero_duration();
    program_curve(MODE_QUART_IN_OUT, VB'(-300), VB'(-1234), '0);
    send_elapsed('0);
    send_elapsed(TIME_MAX);
  endtask

  // Random settings per phase. Most phases sweep elapsed from zero to past
  // the duration, as an animation would; the rest hit random points.
  task automatic test_random_sweeps();
    int unsigned sent, n, style, step;
    longint unsigned e;
    logic [MODE_BITS-1:0] mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? MODE_SPARE_LO
                                                                     : MODE_SPARE_HI)
                                         : MODE_BITS'($urandom_range(0, MODE_QUART_IN_OUT));
      program_curve(mode, pick_value(), pick_value(), pick_duration());
      // leave some phases without any idling
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      n     = $urandom_range(20, 60);
      style = $urandom_range(0, 9);
      step  = (shadow_duration == 0) ? $urandom_range(1, 4000)
                                     : (int'(shadow_duration) + n - 1) / (n - 8);
      if (step == 0) step = 1;
      for (int i = 0; i < n; i++) begin
        if (style < 6) e = longint'(i) * step;
        else if (style < 8) e = $urandom_range(0, int'(shadow_duration) +
                                                   int'(shadow_duration) / 4);
        else e = $urandom_range(0, TIME_MAX);
        if (e > TIME_MAX) e = TIME_MAX;
        send_elapsed(TB'(e));
      end
      sent += n;
    end
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
  endtask

  // hold the receiver off while beats keep coming, so the chain fills and
  // the input stalls until the hold-off ends
  task automatic test_output_backlog();
    program_curve(MODE_QUART_OUT, pick_value(), pick_value(), TB'($urandom_range(50, 500)));
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_off_request = HOLD_OFF_TICKS;
    for (int i = 0; i < BACKLOG_ITEMS; i++) send_elapsed(TB'($urandom_range(0, 600)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: drive tready at the falling edge
  // --------------------------------------------------------------------------
  initial begin : sink_ready_gen
    int unsigned hold_left, gap_left;
    hold_left = 0;
    gap_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_en) gap_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    ease_result_t want;
    logic signed [VB:0] got_value;
    logic got_done;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value = m_axis_tdata[VB:0];
      got_done  = m_axis_tuser[0];
      if (pending_eases.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, actual value %0d done %0d",
                 $time, got_value, got_done);
      end else begin
        want = pending_eases.pop_front();
        if (got_value !== want.value) begin
          mismatch_count++;
          $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                   $time, want.value, got_value);
        end
        if (got_done !== want.done) begin
          mismatch_count++;
          $display("%0t: done_res mismatch, expected %0d, actual %0d",
                   $time, want.done, got_done);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_CURVE_MODE;
    cfg_data_i    = '0;
    // registers as reset loads them
    shadow_mode     = MODE_LINEAR;
    shadow_start    = '0;
    shadow_change   = '0;
    shadow_duration = TB'(1);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_every_mode();
    test_zero_duration();
    test_random_sweeps();
    test_output_backlog();

    // drain everything; late or extra beats are still caught meanwhile
    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // backstop against a hung handshake
  initial begin : run_limit
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ecint_pkg.sv
rtl/core/ecint_div_cell.sv
rtl/core/ecint_curve.sv
rtl/core/ecint_scale.sv
rtl/core/easing_curve_interpolator_top.sv
bench/testbench.sv
